FILE: hw/rtl/shell_command_line_lexer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the command line lexer
// ---------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LINE_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LINE_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCLX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCLX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sclx_pkg.sv
// ---------------------------------------------------------------------------
// sclx_pkg
// Types, character codes and token building functions of the lexer.
// ---------------------------------------------------------------------------
package sclx_pkg;

    localparam int MAX_RES = 4;

    // token kinds
    localparam logic [2:0] KIND_BYTE      = 3'd0;
    localparam logic [2:0] KIND_WORD_END  = 3'd1;
    localparam logic [2:0] KIND_EMPTY     = 3'd2;
    localparam logic [2:0] KIND_LINE_OK   = 3'd3;
    localparam logic [2:0] KIND_UNMATCHED = 3'd4;
    localparam logic [2:0] KIND_BAD_ESC   = 3'd5;

    // separator codes
    localparam logic [3:0] SEP_NONE       = 4'd0;
    localparam logic [3:0] SEP_LT         = 4'd4;
    localparam logic [3:0] SEP_SEMI       = 4'd5;
    localparam logic [3:0] SEP_LPAR       = 4'd6;
    localparam logic [3:0] SEP_RPAR       = 4'd7;
    // doubled operator code is the single operator code plus this
    localparam logic [3:0] SEP_DOUBLE_OFS = 4'd7;

    // pending operator codes (equal to the single operator separator codes)
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_AMP  = 2'd1;
    localparam logic [1:0] OP_GT   = 2'd2;
    localparam logic [1:0] OP_BAR  = 2'd3;

    // quote peek stages
    localparam logic [1:0] QP_IDLE = 2'd0;
    localparam logic [1:0] QP_ONE  = 2'd1;
    localparam logic [1:0] QP_TWO  = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef struct packed {
        logic       in_quote;
        logic       escape_pending;
        logic       word_open;
        logic       any_word_in_line;
        logic [1:0] pending_operator;
        logic [1:0] quote_peek_stage;
        logic       discarding;
    } state_t;

    localparam state_t ST_CLEAR = '0;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_out;
        logic [3:0] separator;
    } result_t;

    // working record while one byte is lexed
    typedef struct packed {
        state_t                    st;
        result_t [MAX_RES-1:0]     res;
        logic [2:0]                n;
    } acc_t;

    function automatic acc_t f_emit(acc_t a, logic [2:0] k, logic [7:0] c,
                                    logic [3:0] s);
        acc_t r;
        r = a;
        if (a.n < 3'(MAX_RES))
        begin
            r.res[a.n[1:0]].kind      = k;
            r.res[a.n[1:0]].char_out  = c;
            r.res[a.n[1:0]].separator = s;
            r.n = a.n + 3'd1;
        end
        return r;
    endfunction

    function automatic acc_t f_add_byte(acc_t a, logic [7:0] c);
        acc_t r;
        r = f_emit(a, KIND_BYTE, c, SEP_NONE);
        r.st.word_open        = 1'b1;
        r.st.any_word_in_line = 1'b1;
        return r;
    endfunction

    function automatic acc_t f_end_word(acc_t a, logic [3:0] s);
        acc_t r;
        r = a;
        if (a.st.word_open && a.st.any_word_in_line)
        begin
            r = f_emit(a, KIND_WORD_END, 8'd0, s);
            r.st.word_open = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] f_op_char(logic [1:0] p);
        logic [7:0] c;
        case (p)
            OP_AMP:  c = CH_AMP;
            OP_GT:   c = CH_GT;
            default: c = CH_BAR;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] f_op_code(logic [7:0] b);
        logic [1:0] p;
        case (b)
            CH_AMP:  p = OP_AMP;
            CH_GT:   p = OP_GT;
            default: p = OP_BAR;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] f_sep_code(logic [7:0] b);
        logic [3:0] s;
        case (b)
            CH_LT:   s = SEP_LT;
            CH_SEMI: s = SEP_SEMI;
            CH_LPAR: s = SEP_LPAR;
            default: s = SEP_RPAR;
        endcase
        return s;
    endfunction

    // ordinary lexing of one byte
    function automatic acc_t f_lex(acc_t a, logic [7:0] b);
        acc_t r;
        r = a;
        if (r.st.escape_pending && b != CH_BSLASH && b != CH_QUOTE)
        begin
            r = f_emit(r, KIND_BAD_ESC, 8'd0, SEP_NONE);
            r.st = ST_CLEAR;
            r.st.discarding = (b != CH_NL);
        end
        else
        begin
            case (b)
                CH_TAB, CH_SPACE:
                begin
                    if (r.st.in_quote)
                        r = f_add_byte(r, b);
                    else
                        r = f_end_word(r, SEP_NONE);
                end
                CH_NL:
                begin
                    r = f_end_word(r, SEP_NONE);
                    r = f_emit(r, r.st.in_quote ? KIND_UNMATCHED : KIND_LINE_OK,
                               8'd0, SEP_NONE);
                    r.st = ST_CLEAR;
                end
                CH_BSLASH:
                begin
                    if (r.st.escape_pending)
                    begin
                        r = f_add_byte(r, b);
                        r.st.escape_pending = 1'b0;
                    end
                    else
                        r.st.escape_pending = 1'b1;
                end
                CH_QUOTE:
                begin
                    if (r.st.escape_pending)
                    begin
                        r = f_add_byte(r, b);
                        r.st.escape_pending = 1'b0;
                    end
                    else
                    begin
                        r.st.in_quote = ~r.st.in_quote;
                        if (!r.st.word_open)
                            r.st.quote_peek_stage = QP_ONE;
                    end
                end
                CH_LT, CH_SEMI, CH_LPAR, CH_RPAR:
                begin
                    if (r.st.in_quote)
                        r = f_add_byte(r, b);
                    else
                    begin
                        r = f_end_word(r, SEP_NONE);
                        r = f_add_byte(r, b);
                        r = f_end_word(r, f_sep_code(b));
                    end
                end
                CH_AMP, CH_GT, CH_BAR:
                begin
                    if (r.st.in_quote)
                        r = f_add_byte(r, b);
                    else
                    begin
                        r = f_end_word(r, SEP_NONE);
                        r = f_add_byte(r, b);
                        r.st.pending_operator = f_op_code(b);
                    end
                end
                default:
                    r = f_add_byte(r, b);
            endcase
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sclx_byte_if.sv
// ---------------------------------------------------------------------------
// sclx_byte_if
// Input channel: one command line byte per transaction.
// ---------------------------------------------------------------------------
interface sclx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: hw/rtl/sclx_token_if.sv
// ---------------------------------------------------------------------------
// sclx_token_if
// Output channel: one token per transaction.
// ---------------------------------------------------------------------------
interface sclx_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [3:0] separator;
    logic       last_of_run;

    modport source (output valid, output kind, output char_out, output separator,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input char_out, input separator,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/shell_command_line_lexer.sv
// ---------------------------------------------------------------------------
// shell_command_line_lexer
// Byte-at-a-time shell command line tokenizer.
// ---------------------------------------------------------------------------
// Takes one command line byte per transaction on chars and emits tokens on
// tokens: word bytes, word ends with a separator code, empty words and a line
// status at each newline. A byte is lexed in the cycle it is accepted and its
// zero to four tokens land in a four-slot result register that drains one
// token per cycle while tokens.ready is high, last_of_run marking the final
// token of each byte. Bytes that give one token or none stream at one byte
// per cycle while tokens.ready is high; a byte with more holds the input until
// its tokens drain one slot at a time through the single token port.
// Operators & > | are held back one byte to spot a doubled form. After a bad
// escape the rest of the line is dropped without tokens.
`include "shell_command_line_lexer_assert.svh"

module shell_command_line_lexer
    import sclx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sclx_byte_if.sink    chars,
    sclx_token_if.source tokens
);

    state_t                st_reg;
    state_t                st_next;
    result_t [MAX_RES-1:0] step_res;
    logic [2:0]            step_count;
    logic                  can_load;
    logic                  accept;

    assign chars.ready = can_load;
    assign accept      = chars.valid && chars.ready;

    sclx_step u_step (
        .st      (st_reg),
        .byte_in (chars.byte_in),
        .st_next (st_next),
        .res     (step_res),
        .count   (step_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_CLEAR;
        else if (accept)
            st_reg <= st_next;
    end

    sclx_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res_in   (step_res),
        .count_in (step_count),
        .can_load (can_load),
        .tokens   (tokens)
    );

    // while dropping a line nothing else of the line state may survive
    `SCLX_ASSERT_IMP(a_discard_clean, st_reg.discarding, st_reg.pending_operator == OP_NONE && !st_reg.in_quote && !st_reg.escape_pending && !st_reg.word_open, "line state left while discarding")
    // a newline always leaves a fresh line
    `SCLX_ASSERT_NXT(a_newline_clears, accept && chars.byte_in == CH_NL, st_reg == ST_CLEAR, "line state not cleared by newline")
    // tokens of one byte follow each other with no gap
    `SCLX_ASSERT_NXT(a_run_continues, tokens.valid && tokens.ready && !tokens.last_of_run, tokens.valid, "token run broken")

endmodule

FILE: hw/rtl/sclx_step.sv
// ---------------------------------------------------------------------------
// sclx_step
// Lexes one byte against the line state: next state and up to four tokens.
// ---------------------------------------------------------------------------
module sclx_step
    import sclx_pkg::*;
(
    input  state_t                st,
    input  logic [7:0]            byte_in,
    output state_t                st_next,
    output result_t [MAX_RES-1:0] res,
    output logic [2:0]            count
);

    acc_t a;
    logic do_lex;

    always_comb
    begin
        a      = '0;
        a.st   = st;
        do_lex = 1'b0;
        if (st.discarding)
        begin
            if (byte_in == CH_NL)
                a.st = ST_CLEAR;
        end
        else if (st.pending_operator != OP_NONE)
        begin
            a.st.pending_operator = OP_NONE;
            if (byte_in == f_op_char(st.pending_operator))
            begin
                a = f_add_byte(a, byte_in);
                a = f_end_word(a, {2'b00, st.pending_operator} + SEP_DOUBLE_OFS);
            end
            else
            begin
                // single operator: close it, then lex the byte as usual
                a      = f_end_word(a, {2'b00, st.pending_operator});
                do_lex = 1'b1;
            end
        end
        else if (st.quote_peek_stage == QP_ONE)
        begin
            a.st.quote_peek_stage = QP_IDLE;
            if (byte_in == CH_QUOTE)
            begin
                a.st.in_quote         = ~a.st.in_quote;
                a.st.quote_peek_stage = QP_TWO;
            end
            else
                do_lex = 1'b1;
        end
        else if (st.quote_peek_stage == QP_TWO)
        begin
            a.st.quote_peek_stage = QP_IDLE;
            // "" at word start then white space or newline: empty word
            if (byte_in == CH_SPACE || byte_in == CH_TAB || byte_in == CH_NL)
            begin
                a = f_emit(a, KIND_EMPTY, 8'd0, SEP_NONE);
                a.st.any_word_in_line = 1'b1;
            end
            do_lex = 1'b1;
        end
        else
        begin
            a.st.quote_peek_stage = QP_IDLE;
            do_lex = 1'b1;
        end
        if (do_lex)
            a = f_lex(a, byte_in);
    end

    assign st_next = a.st;
    assign res     = a.res;
    assign count   = a.n;

endmodule

FILE: hw/rtl/sclx_outbuf.sv
// ---------------------------------------------------------------------------
// sclx_outbuf
// Result register: holds the tokens of one byte and hands them out in order.
// ---------------------------------------------------------------------------
module sclx_outbuf
    import sclx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t [MAX_RES-1:0] res_in,
    input  logic [2:0]            count_in,
    output logic                  can_load,
    sclx_token_if.source          tokens
);

    result_t [MAX_RES-1:0] res_reg;
    logic [1:0]            pos_reg;
    logic [1:0]            pos_next;
    logic [2:0]            left_reg;
    logic [2:0]            left_next;
    logic                  pop;

    assign pop = tokens.valid && tokens.ready;
    // empty, or the last token goes out this cycle
    assign can_load = (left_reg == 3'd0) || (left_reg == 3'd1 && tokens.ready);

    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        if (load)
        begin
            pos_next  = 2'd0;
            left_next = count_in;
        end
        else if (pop)
        begin
            pos_next  = pos_reg + 2'd1;
            left_next = left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            left_reg <= 3'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign tokens.valid       = (left_reg != 3'd0);
    assign tokens.kind        = res_reg[pos_reg].kind;
    assign tokens.char_out    = res_reg[pos_reg].char_out;
    assign tokens.separator   = res_reg[pos_reg].separator;
    assign tokens.last_of_run = (left_reg == 3'd1);

endmodule
